### rtl/aen_pkg.sv
// Shared types, constants and name tables of the Accept-Encoding negotiator.
// Used by aen_front, aen_queue, aen_back and accept_encoding_negotiator.
// Depends on nothing.
package aen_pkg;

    localparam int CODING_COUNT = 4;
    localparam int CODE_IDX_W   = $clog2(CODING_COUNT);
    localparam int POS_W        = 4;
    localparam int Q_W          = 10;
    localparam int CHOICE_W     = 3;

    localparam logic [Q_W-1:0]      Q_ONE        = 10'd1000;
    localparam logic [CHOICE_W-1:0] CHOICE_NONE  = 3'd0;
    localparam logic [CHOICE_W-1:0] CHOICE_ERROR = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [7:0] lc;
        logic       present;
        logic       last;
        logic       is_space;
        logic       is_comma;
        logic       is_semi;
        logic       is_dot;
        logic       is_q;
        logic       is_eq;
        logic       is_digit;
        logic [3:0] digit;
    } token_t;

    function automatic logic [POS_W-1:0] coding_len(input logic [CODE_IDX_W-1:0] idx);
        logic [POS_W-1:0] len;
        len = '0;
        unique case (idx)
            2'd0:    len = 4'd2;
            2'd1:    len = 4'd4;
            2'd2:    len = 4'd1;
            2'd3:    len = 4'd8;
            default: len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] coding_char(input logic [CODE_IDX_W-1:0] idx,
                                               input logic [POS_W-1:0] pos);
        logic [63:0] name;
        name = '0;
        unique case (idx)
            2'd0:    name = {48'h0, "rb"};
            2'd1:    name = {32'h0, "pizg"};
            2'd2:    name = {56'h0, "*"};
            2'd3:    name = "ytitnedi";
            default: name = '0;
        endcase
        return (pos < 4'd8) ? name[pos[2:0]*8 +: 8] : 8'h00;
    endfunction

endpackage

### rtl/accept_encoding_negotiator.sv
// Accept-Encoding negotiator: one header byte per cycle in, one choice per header out.
// The last byte passes the front register and queue; aen_back then registers the choice.
// One byte per cycle while full is low; full rises when the queue fills or a choice waits.
// Reset (rst_n low, asynchronous) empties the front stage and the queue and clears the parser; no sweep.
// Depends on aen_pkg, aen_front, aen_queue and aen_back.
module accept_encoding_negotiator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   header_byte,
    input  logic                         byte_present,
    input  logic                         last,
    output logic                         empty,
    input  logic                         pop,
    output logic [aen_pkg::CHOICE_W-1:0] choice
);
    import aen_pkg::*;

    logic   f_push;
    token_t f_tok;
    logic   q_full;
    logic   q_pop;
    token_t q_tok;
    logic   q_empty;

    aen_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .header_byte  (header_byte),
        .byte_present (byte_present),
        .last         (last),
        .tok_push     (f_push),
        .tok          (f_tok),
        .tok_full     (q_full)
    );

    aen_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_tok),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_tok),
        .q_empty (q_empty)
    );

    aen_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (q_tok),
        .tok_empty (q_empty),
        .tok_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .choice    (choice)
    );

endmodule

### rtl/aen_front.sv
// Input stage: registers one header byte per request and classifies it.
// Depends on aen_pkg.
module aen_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [7:0]      header_byte,
    input  logic            byte_present,
    input  logic            last,
    output logic            tok_push,
    output aen_pkg::token_t tok,
    input  logic            tok_full
);
    import aen_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    token_t tok_reg;
    token_t tok_next;
    logic   accept;

    assign full     = valid_reg && tok_full;
    assign accept   = push && !full;
    assign tok_push = valid_reg && !tok_full;
    assign tok      = tok_reg;

    always_comb
    begin
        tok_next          = tok_reg;
        valid_next        = accept || (valid_reg && tok_full);
        if (accept)
        begin
            tok_next.lc       = (header_byte >= CH_UP_A && header_byte <= CH_UP_Z) ?
                                header_byte + CASE_OFS : header_byte;
            tok_next.present  = byte_present;
            tok_next.last     = last;
            tok_next.is_space = (header_byte == CH_SPACE);
            tok_next.is_comma = (header_byte == CH_COMMA);
            tok_next.is_semi  = (header_byte == CH_SEMI);
            tok_next.is_dot   = (header_byte == CH_DOT);
            tok_next.is_q     = (header_byte == CH_Q);
            tok_next.is_eq    = (header_byte == CH_EQ);
            tok_next.is_digit = (header_byte >= CH_ZERO && header_byte <= CH_NINE);
            tok_next.digit    = 4'(header_byte - CH_ZERO);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && tok_full |=> valid_reg && $stable(tok_reg))
        else $error("front stage lost a held request");

    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> valid_reg)
        else $error("front stage full while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> valid_reg)
        else $error("accepted request not held");

endmodule

### rtl/aen_queue.sv
// Two-entry token queue between the front stage and the parser.
// Depends on aen_pkg.
module aen_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  aen_pkg::token_t wr_data,
    output logic            q_full,
    input  logic            rd_en,
    output aen_pkg::token_t rd_data,
    output logic            q_empty
);
    import aen_pkg::*;

    token_t     mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_wr) - 2'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue write not counted");

endmodule

### rtl/aen_back.sv
// Parser: walks tokens through the Accept-Encoding grammar, tracks the best
// quality and registers one choice per header. Depends on aen_pkg.
module aen_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  aen_pkg::token_t                 tok,
    input  logic                            tok_empty,
    output logic                            tok_pop,
    output logic                            empty,
    input  logic                            pop,
    output logic [aen_pkg::CHOICE_W-1:0]    choice
);
    import aen_pkg::*;

    typedef enum logic [2:0] {
        PH_NAME,
        PH_AFTER_SEMI,
        PH_EXPECT_Q,
        PH_EXPECT_EQ,
        PH_EXPECT_DIGIT,
        PH_INT,
        PH_FRAC,
        PH_REST
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic                    lead_reg, lead_next;
    logic                    pend_reg, pend_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CODING_COUNT-1:0] alive_reg, alive_next;
    logic [1:0]              ip_reg, ip_next;
    logic [Q_W-1:0]          fv_reg, fv_next;
    logic [1:0]              fd_reg, fd_next;
    logic                    above_reg, above_next;
    logic [Q_W-1:0]          best_reg, best_next;
    logic                    have_reg, have_next;
    logic [CODING_COUNT-1:0] tie_reg, tie_next;
    logic                    err_reg, err_next;
    logic                    any_reg, any_next;
    logic                    res_valid_reg, res_valid_next;
    logic [CHOICE_W-1:0]     res_reg, res_next;

    logic                    consume;
    logic                    comma_hit;
    logic                    do_end;
    phase_t                  s_phase;
    logic [POS_W-1:0]        s_pos;
    logic [CODING_COUNT-1:0] s_alive;
    logic [1:0]              s_ip;
    logic [Q_W-1:0]          s_fv;
    logic [1:0]              s_fd;
    logic                    s_above;
    logic [Q_W:0]            q_wide;
    logic [Q_W-1:0]          q;
    logic [CODING_COUNT-1:0] hit;

    assign consume = !tok_empty && !(tok.last && res_valid_reg && !pop);
    assign tok_pop = consume;
    assign empty   = !res_valid_reg;
    assign choice  = res_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        lead_next      = lead_reg;
        pend_next      = pend_reg;
        pos_next       = pos_reg;
        alive_next     = alive_reg;
        ip_next        = ip_reg;
        fv_next        = fv_reg;
        fd_next        = fd_reg;
        above_next     = above_reg;
        best_next      = best_reg;
        have_next      = have_reg;
        tie_next       = tie_reg;
        err_next       = err_reg;
        any_next       = any_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        comma_hit      = 1'b0;
        q_wide         = '0;
        q              = '0;
        hit            = '0;

        if (consume && tok.present)
        begin
            any_next = 1'b1;
            if (!err_reg)
            begin
                if (tok.is_comma)
                begin
                    comma_hit  = 1'b1;
                    phase_next = PH_NAME;
                    lead_next  = 1'b0;
                    pend_next  = 1'b0;
                    pos_next   = '0;
                    alive_next = '1;
                    ip_next    = '0;
                    fv_next    = '0;
                    fd_next    = '0;
                    above_next = 1'b0;
                end
                else if (phase_reg == PH_NAME)
                begin
                    if (tok.is_semi)
                    begin
                        phase_next = PH_AFTER_SEMI;
                    end
                    else if (tok.is_space)
                    begin
                        if (pos_reg == '0 && !lead_reg && !pend_reg)
                        begin
                            lead_next = 1'b1;
                        end
                        else
                        begin
                            if (pend_reg)
                            begin
                                alive_next = '0;
                                pos_next   = (pos_reg == '1) ? pos_reg : pos_reg + 4'd1;
                            end
                            pend_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (pend_reg)
                        begin
                            alive_next = '0;
                            pend_next  = 1'b0;
                            pos_next   = (pos_reg == '1) ? pos_reg : pos_reg + 4'd1;
                        end
                        for (int i = 0; i < CODING_COUNT; i++)
                        begin
                            if (pos_next >= coding_len(CODE_IDX_W'(i)) ||
                                coding_char(CODE_IDX_W'(i), pos_next) != tok.lc)
                            begin
                                alive_next[i] = 1'b0;
                            end
                        end
                        pos_next = (pos_next == '1) ? pos_next : pos_next + 4'd1;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_AFTER_SEMI:
                        begin
                            if (tok.is_space)  phase_next = PH_EXPECT_Q;
                            else if (tok.is_q) phase_next = PH_EXPECT_EQ;
                            else               err_next   = 1'b1;
                        end
                        PH_EXPECT_Q:
                        begin
                            if (tok.is_q) phase_next = PH_EXPECT_EQ;
                            else          err_next   = 1'b1;
                        end
                        PH_EXPECT_EQ:
                        begin
                            if (tok.is_eq) phase_next = PH_EXPECT_DIGIT;
                            else           err_next   = 1'b1;
                        end
                        PH_EXPECT_DIGIT:
                        begin
                            if (tok.is_digit && tok.digit <= 4'd1)
                            begin
                                ip_next    = 2'(tok.digit);
                                phase_next = PH_INT;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        PH_INT:
                        begin
                            if (tok.is_digit)
                            begin
                                if (ip_reg[0] || tok.digit > 4'd1 || above_reg)
                                begin
                                    above_next = 1'b1;
                                    ip_next    = 2'd1;
                                end
                                else
                                begin
                                    ip_next = 2'(tok.digit);
                                end
                            end
                            else if (tok.is_dot)
                            begin
                                phase_next = PH_FRAC;
                            end
                            else
                            begin
                                phase_next = PH_REST;
                            end
                        end
                        PH_FRAC:
                        begin
                            if (tok.is_digit)
                            begin
                                if (ip_reg != 2'd0 && tok.digit != 4'd0)
                                begin
                                    above_next = 1'b1;
                                end
                                if (fd_reg != 2'd3)
                                begin
                                    fv_next = Q_W'(fv_reg * 10'd10) + Q_W'(tok.digit);
                                    fd_next = fd_reg + 2'd1;
                                end
                            end
                            else
                            begin
                                phase_next = PH_REST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end

        // close the item: on a comma use the item as it stood, on last use the updated one
        s_phase = comma_hit ? phase_reg : phase_next;
        s_pos   = comma_hit ? pos_reg   : pos_next;
        s_alive = comma_hit ? alive_reg : alive_next;
        s_ip    = comma_hit ? ip_reg    : ip_next;
        s_fv    = comma_hit ? fv_reg    : fv_next;
        s_fd    = comma_hit ? fd_reg    : fd_next;
        s_above = comma_hit ? above_reg : above_next;
        do_end  = consume && !err_next && (comma_hit || tok.last);

        if (do_end)
        begin
            if (s_phase == PH_AFTER_SEMI || s_phase == PH_EXPECT_Q ||
                s_phase == PH_EXPECT_EQ || s_phase == PH_EXPECT_DIGIT)
            begin
                err_next = 1'b1;
            end
            else if (s_phase != PH_NAME && (s_above || s_ip > 2'd1))
            begin
                err_next = 1'b1;
            end
            else
            begin
                if (s_phase == PH_NAME)
                begin
                    q_wide = {1'b0, Q_ONE};
                end
                else
                begin
                    q_wide = s_ip[0] ? {1'b0, Q_ONE} : '0;
                    case (s_fd)
                        2'd1:    q_wide = q_wide + (Q_W+1)'(s_fv * 10'd100);
                        2'd2:    q_wide = q_wide + (Q_W+1)'(s_fv * 10'd10);
                        2'd3:    q_wide = q_wide + (Q_W+1)'(s_fv);
                        default: q_wide = q_wide;
                    endcase
                end
                q = q_wide[Q_W-1:0];
                for (int i = 0; i < CODING_COUNT; i++)
                begin
                    hit[i] = s_alive[i] && (coding_len(CODE_IDX_W'(i)) == s_pos);
                end
                if (hit != '0)
                begin
                    if (!have_reg || best_reg < q)
                    begin
                        have_next = 1'b1;
                        best_next = q;
                        tie_next  = hit;
                    end
                    else if (best_reg == q)
                    begin
                        tie_next = tie_reg | hit;
                    end
                end
            end
        end

        if (consume && tok.last)
        begin
            res_valid_next = 1'b1;
            if (err_next)
            begin
                res_next = CHOICE_ERROR;
            end
            else
            begin
                res_next = CHOICE_NONE;
                if (any_next && have_next)
                begin
                    for (int i = CODING_COUNT - 1; i >= 0; i--)
                    begin
                        if (tie_next[i])
                        begin
                            res_next = CHOICE_W'(i + 1);
                        end
                    end
                end
            end
            phase_next = PH_NAME;
            lead_next  = 1'b0;
            pend_next  = 1'b0;
            pos_next   = '0;
            alive_next = '1;
            ip_next    = '0;
            fv_next    = '0;
            fd_next    = '0;
            above_next = 1'b0;
            best_next  = '0;
            have_next  = 1'b0;
            tie_next   = '0;
            err_next   = 1'b0;
            any_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NAME;
            lead_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pos_reg       <= '0;
            alive_reg     <= '1;
            ip_reg        <= '0;
            fv_reg        <= '0;
            fd_reg        <= '0;
            above_reg     <= 1'b0;
            best_reg      <= '0;
            have_reg      <= 1'b0;
            tie_reg       <= '0;
            err_reg       <= 1'b0;
            any_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            lead_reg      <= lead_next;
            pend_reg      <= pend_next;
            pos_reg       <= pos_next;
            alive_reg     <= alive_next;
            ip_reg        <= ip_next;
            fv_reg        <= fv_next;
            fd_reg        <= fd_next;
            above_reg     <= above_next;
            best_reg      <= best_next;
            have_reg      <= have_next;
            tie_reg       <= tie_next;
            err_reg       <= err_next;
            any_reg       <= any_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !pop |=> res_valid_reg && $stable(res_reg))
        else $error("pending choice dropped or changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        consume && tok.last |=> !err_reg && !have_reg && !any_reg && phase_reg == PH_NAME)
        else $error("header state not cleared after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_reg <= CHOICE_ERROR)
        else $error("choice code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        have_reg |-> tie_reg != '0 && best_reg <= Q_ONE)
        else $error("best quality tracking inconsistent");

endmodule

### dv/accept_encoding_negotiator_test.sv
`timescale 1ns / 100ps
// Self-checking bench for accept_encoding_negotiator: feeds Accept-Encoding header values a
// byte at a time and compares every choice against a cycle-free predictor of the negotiation.
// Depends on aen_pkg and the accept_encoding_negotiator RTL.

import aen_pkg::*;

typedef enum logic [2:0] {
    ST_NAME,
    ST_AFTER_SEMI,
    ST_WANT_Q,
    ST_WANT_EQ,
    ST_WANT_DIGIT,
    ST_INT,
    ST_FRAC,
    ST_TAIL
} qphase_t;

localparam logic [CHOICE_W-1:0] CHOICE_BR       = 3'd1;
localparam logic [CHOICE_W-1:0] CHOICE_GZIP     = 3'd2;
localparam logic [CHOICE_W-1:0] CHOICE_ANY      = 3'd3;
localparam logic [CHOICE_W-1:0] CHOICE_IDENTITY = 3'd4;
localparam logic [7:0]          CH_ONE          = 8'h31;

class negotiation_tracker_t;
    qphase_t             phase;
    bit                  lead_sp;
    bit                  pend_sp;
    bit [POS_W-1:0]      pos;
    bit [3:0]            alive;
    bit [1:0]            int_part;
    bit [Q_W-1:0]        frac_val;
    bit [1:0]            frac_cnt;
    bit                  over_one;
    bit [Q_W-1:0]        best_q;
    bit                  have_best;
    bit [3:0]            ties;
    bit                  err;
    bit                  saw_byte;
    string               coding_txt[4];
    bit [CHOICE_W-1:0]   expected_choices[$];
    int                  mismatches;
    int                  headers;
    int                  error_headers;
    int                  checked;

    function new();
        coding_txt = '{"br", "gzip", "*", "identity"};
        mismatches = 0;
        headers = 0;
        error_headers = 0;
        checked = 0;
        clear_header();
    endfunction

    function void clear_entry();
        phase = ST_NAME;
        lead_sp = 1'b0;
        pend_sp = 1'b0;
        pos = '0;
        alive = '1;
        int_part = '0;
        frac_val = '0;
        frac_cnt = '0;
        over_one = 1'b0;
    endfunction

    function void clear_header();
        clear_entry();
        best_q = '0;
        have_best = 1'b0;
        ties = '0;
        err = 1'b0;
        saw_byte = 1'b0;
    endfunction

    function void advance_pos();
        if (pos < 4'd15)
            pos++;
    endfunction

    function bit [CHOICE_W-1:0] coding_choice(int idx);
        case (idx)
            0:       return CHOICE_BR;
            1:       return CHOICE_GZIP;
            2:       return CHOICE_ANY;
            default: return CHOICE_IDENTITY;
        endcase
    endfunction

    function void match_letter(bit [7:0] c);
        bit [7:0] lc;
        lc = c;
        if (c >= CH_UP_A && c <= CH_UP_Z)
            lc = c + CASE_OFS;
        for (int i = 0; i < CODING_COUNT; i++)
            if (pos >= coding_txt[i].len() || coding_txt[i][pos] != lc)
                alive[i] = 1'b0;
        advance_pos();
    endfunction

    function void name_char(bit [7:0] b);
        if (b == CH_SPACE)
        begin
            if (pos == 0 && !lead_sp && !pend_sp)
            begin
                lead_sp = 1'b1;
            end
            else
            begin
                if (pend_sp)
                begin
                    alive = '0;
                    advance_pos();
                end
                pend_sp = 1'b1;
            end
            return;
        end
        if (pend_sp)
        begin
            alive = '0;
            pend_sp = 1'b0;
            advance_pos();
        end
        match_letter(b);
    endfunction

    function void close_entry();
        int unsigned q;
        bit [3:0]    hit;
        hit = '0;
        if (err)
            return;
        if (phase == ST_AFTER_SEMI || phase == ST_WANT_Q || phase == ST_WANT_EQ
            || phase == ST_WANT_DIGIT)
        begin
            err = 1'b1;
            return;
        end
        if (phase == ST_NAME)
        begin
            q = Q_ONE;
        end
        else
        begin
            if (over_one || int_part > 1)
            begin
                err = 1'b1;
                return;
            end
            q = int_part * Q_ONE;
            if (frac_cnt == 1)
                q += frac_val * 100;
            else if (frac_cnt == 2)
                q += frac_val * 10;
            else if (frac_cnt == 3)
                q += frac_val;
        end
        for (int i = 0; i < CODING_COUNT; i++)
            if (alive[i] && coding_txt[i].len() == pos)
                hit[i] = 1'b1;
        if (hit != 0)
        begin
            if (!have_best || best_q < q)
            begin
                have_best = 1'b1;
                best_q = Q_W'(q);
                ties = hit;
            end
            else if (best_q == q)
            begin
                ties |= hit;
            end
        end
    endfunction

    function void quality_char(bit [7:0] b);
        bit is_digit;
        int d;
        int v;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        d = is_digit ? b - CH_ZERO : 0;
        case (phase)
            ST_AFTER_SEMI:
                if (b == CH_SPACE)
                    phase = ST_WANT_Q;
                else if (b == CH_Q)
                    phase = ST_WANT_EQ;
                else
                    err = 1'b1;
            ST_WANT_Q:
                if (b == CH_Q)
                    phase = ST_WANT_EQ;
                else
                    err = 1'b1;
            ST_WANT_EQ:
                if (b == CH_EQ)
                    phase = ST_WANT_DIGIT;
                else
                    err = 1'b1;
            ST_WANT_DIGIT:
                if (b == CH_ZERO || b == CH_ONE)
                begin
                    int_part = 2'(b == CH_ONE);
                    phase = ST_INT;
                end
                else
                begin
                    err = 1'b1;
                end
            ST_INT:
                if (is_digit)
                begin
                    v = int_part[0] * 10 + d;
                    if (v > 1 || over_one)
                    begin
                        over_one = 1'b1;
                        int_part = 2'd1;
                    end
                    else
                    begin
                        int_part = 2'(v);
                    end
                end
                else if (b == CH_DOT)
                begin
                    phase = ST_FRAC;
                end
                else
                begin
                    phase = ST_TAIL;
                end
            ST_FRAC:
                if (is_digit)
                begin
                    if (int_part != 0 && d != 0)
                        over_one = 1'b1;
                    if (frac_cnt < 3)
                    begin
                        frac_val = Q_W'(frac_val * 10 + d);
                        frac_cnt++;
                    end
                end
                else
                begin
                    phase = ST_TAIL;
                end
            default: ;
        endcase
    endfunction

    function void take_request(bit [7:0] b, bit present, bit fin);
        bit [CHOICE_W-1:0] result;
        if (present)
        begin
            saw_byte = 1'b1;
            if (!err)
            begin
                if (b == CH_COMMA)
                begin
                    close_entry();
                    clear_entry();
                end
                else if (phase == ST_NAME)
                begin
                    if (b == CH_SEMI)
                        phase = ST_AFTER_SEMI;
                    else
                        name_char(b);
                end
                else
                begin
                    quality_char(b);
                end
            end
        end
        if (!fin)
            return;
        close_entry();
        result = CHOICE_NONE;
        if (err)
        begin
            result = CHOICE_ERROR;
            error_headers++;
        end
        else if (saw_byte && have_best)
        begin
            for (int i = CODING_COUNT - 1; i >= 0; i--)
                if (ties[i])
                    result = coding_choice(i);
        end
        expected_choices.push_back(result);
        headers++;
        clear_header();
    endfunction

    function void check_choice(bit [CHOICE_W-1:0] got);
        bit [CHOICE_W-1:0] want;
        if (expected_choices.size() == 0)
        begin
            $error("choice: expected nothing, actual %0d", got);
            mismatches++;
            return;
        end
        want = expected_choices.pop_front();
        checked++;
        if (want != got)
        begin
            $error("choice: expected %0d, actual %0d", want, got);
            mismatches++;
        end
    endfunction
endclass

module accept_encoding_negotiator_test;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [7:0]          header_byte;
    logic                byte_present;
    logic                last;
    logic                empty;
    logic                pop;
    logic [CHOICE_W-1:0] choice;

    negotiation_tracker_t tracker;
    bit [7:0]             hdr[$];
    int                   send_idle_pct;
    int                   pop_stall_pct;
    int                   sent_items;

    accept_encoding_negotiator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .header_byte  (header_byte),
        .byte_present (byte_present),
        .last         (last),
        .empty        (empty),
        .pop          (pop),
        .choice       (choice)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99) >= pop_stall_pct);
            @(posedge clk);
            if (pop && !empty)
                tracker.check_choice(choice);
        end
    end

    task automatic push_request(input bit [7:0] b, input bit present, input bit fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            header_byte <= 8'($urandom_range(255));
            byte_present <= 1'($urandom_range(1));
            last <= 1'($urandom_range(1));
            @(negedge clk);
        end
        push <= 1'b1;
        header_byte <= b;
        byte_present <= present;
        last <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.take_request(b, present, fin);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            hdr.push_back(s[i]);
    endtask

    task automatic send_header();
        bit on_byte;
        on_byte = ($urandom_range(4) != 0);
        if (hdr.size() == 0)
        begin
            push_request(8'($urandom_range(255)), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < hdr.size(); i++)
        begin
            if ($urandom_range(9) == 0)
                push_request(8'($urandom_range(255)), 1'b0, 1'b0);
            push_request(hdr[i], 1'b1, on_byte && i == hdr.size() - 1);
        end
        if (!on_byte)
            push_request(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic send_text(input string s);
        hdr.delete();
        add_text(s);
        send_header();
    endtask

    task automatic add_entry();
        string    nm;
        bit [7:0] c;
        if ($urandom_range(7) == 0)
            add_text(" ");
        case ($urandom_range(11))
            0, 1:    nm = "br";
            2, 3:    nm = "gzip";
            4:       nm = "*";
            5, 6:    nm = "identity";
            7:       nm = "deflate";
            8:       nm = "";
            9:       nm = "gz";
            10:      nm = "b r";
            default: nm = "x-some-very-long-coding";
        endcase
        for (int i = 0; i < nm.len(); i++)
        begin
            c = nm[i];
            if (c >= "a" && c <= "z" && $urandom_range(3) == 0)
                c = c - CASE_OFS;
            hdr.push_back(c);
        end
        case ($urandom_range(7))
            0:       add_text(" ");
            1:       add_text("  ");
            default: ;
        endcase
        if ($urandom_range(9) < 4)
            return;
        case ($urandom_range(19))
            0:       add_text(";  q=");
            1:       add_text(";Q=");
            2, 3, 4, 5, 6, 7, 8, 9, 10: add_text(";q=");
            default: add_text("; q=");
        endcase
        case ($urandom_range(17))
            0:       add_text("0");
            1:       add_text("1");
            2:       add_text("0.5");
            3:       add_text("0.25");
            4:       add_text("0.125");
            5:       add_text("0.1239");
            6:       add_text("1.000");
            7:       add_text("1.");
            8:       add_text("0.");
            9:       add_text("01");
            10:      add_text("1.0001");
            11:      add_text("2");
            12:      add_text("0.5e3");
            13:      add_text("1;q=0");
            14:      add_text("1.5");
            15:      add_text("0.000");
            default:
            begin
                add_text("0.");
                repeat ($urandom_range(1, 5))
                    hdr.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
        endcase
    endtask

    task automatic build_header();
        int kind;
        kind = $urandom_range(99);
        hdr.delete();
        if (kind >= 85)
        begin
            repeat ($urandom_range(12))
            begin
                if ($urandom_range(2) == 0)
                begin
                    case ($urandom_range(4))
                        0:       hdr.push_back(CH_COMMA);
                        1:       hdr.push_back(CH_SEMI);
                        2:       hdr.push_back(CH_Q);
                        3:       hdr.push_back(CH_EQ);
                        default: hdr.push_back(8'(CH_ZERO + $urandom_range(1)));
                    endcase
                end
                else
                begin
                    hdr.push_back(8'($urandom_range(255)));
                end
            end
            return;
        end
        for (int k = $urandom_range(1, 4); k > 0; k--)
        begin
            add_entry();
            if (k > 1)
            begin
                if ($urandom_range(1))
                    add_text(",");
                else
                    add_text(", ");
            end
        end
        if (kind >= 70 && hdr.size() > 0)
        begin
            case ($urandom_range(2))
                0:       hdr[$urandom_range(hdr.size() - 1)] = 8'($urandom_range(255));
                1:       hdr = hdr[0:$urandom_range(hdr.size() - 1)];
                default: hdr.insert($urandom_range(hdr.size() - 1), CH_SEMI);
            endcase
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        push = 1'b0;
        header_byte = '0;
        byte_present = 1'b0;
        last = 1'b0;
        sent_items = 0;
        send_idle_pct = 15;
        pop_stall_pct = 81;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_request(8'h00, 1'b0, 1'b1);
        hdr = '{8'h00, CH_COMMA, 8'hFF};
        send_header();
        send_text("*;q=0");
        push_request("b", 1'b1, 1'b0);
        push_request(8'hFF, 1'b0, 1'b0);
        push_request("r", 1'b1, 1'b0);
        push_request(CH_COMMA, 1'b1, 1'b0);
        send_text("BR");
        send_text("*;q=01");
        send_text("gzip;q=1.0001");
        send_text("q;x");

        while (sent_items < 233)
        begin
            build_header();
            send_header();
        end
        send_idle_pct = 81;
        pop_stall_pct = 15;
        while (sent_items < 466)
        begin
            build_header();
            send_header();
        end
        send_idle_pct = 0;
        pop_stall_pct = 0;
        while (sent_items < 700)
        begin
            build_header();
            send_header();
        end
        push <= 1'b0;

        while (tracker.expected_choices.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Negotiated %0d header values from %0d input items; %0d choices compared.",
                 tracker.headers, sent_items, tracker.checked);
        $display("%0d of those headers were malformed and had to report an error.",
                 tracker.error_headers);
        if (tracker.mismatches == 0 && tracker.expected_choices.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
